// File: sv/rhbd_pkg.sv
// rhbd_pkg: shared types and constants for the rgb half box downscaler
// no dependencies; imported by every module of the block except rhbd_ram

package rhbd_pkg;

    localparam int unsigned DEF_WIDTH_LIMIT = 2048;
    localparam int unsigned DEF_MAX_HEIGHT  = 2048;

    localparam int unsigned CFG_DIM_W   = 12;
    localparam int unsigned CHAN_W      = 8;
    localparam int unsigned PAIR_W      = CHAN_W + 1;
    localparam int unsigned SUM_W       = CHAN_W + 2;
    localparam int unsigned LINE_W      = 3 * PAIR_W;
    localparam int unsigned APB_DATA_W  = 32;
    localparam int unsigned APB_ADDR_W  = 3;
    localparam int unsigned REG_IDX_LSB = 2;

    localparam logic [CFG_DIM_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_DIM_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [CHAN_W-1:0] pix_red;
        logic [CHAN_W-1:0] pix_green;
        logic [CHAN_W-1:0] pix_blue;
    } pix_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic              row_end;
        logic              frame_end;
    } pix_out_t;

    // per-request decisions handed from the position tracker to the datapath
    typedef struct packed {
        logic self_pair;
        logic double_row;
        logic wr_en;
        logic emit;
        logic row_end;
        logic frame_end;
    } rhbd_ctl_t;

endpackage

// File: sv/rhbd_ram.sv
// rhbd_ram: generic single-write, single-read RAM with registered read
// no dependencies

module rhbd_ram #(
    parameter int unsigned WIDTH = 27,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/rhbd_regs.sv
// rhbd_regs: apb register file for frame width and height
// depends on rhbd_pkg; gives clamped frame dimensions and a write strobe

module rhbd_regs import rhbd_pkg::*; #(
    parameter int unsigned WIDTH_LIMIT = DEF_WIDTH_LIMIT,
    parameter int unsigned MAX_HEIGHT  = DEF_MAX_HEIGHT,
    localparam int unsigned WDW = $clog2(WIDTH_LIMIT + 1),
    localparam int unsigned HDW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [WDW-1:0]        width_eff,
    output logic [HDW-1:0]        height_eff,
    output logic                  cfg_we
);

    localparam int unsigned CMP_WW = (WDW > CFG_DIM_W) ? WDW : CFG_DIM_W;
    localparam int unsigned CMP_HW = (HDW > CFG_DIM_W) ? HDW : CFG_DIM_W;

    logic [CFG_DIM_W-1:0] frame_width_reg, frame_width_next;
    logic [CFG_DIM_W-1:0] frame_height_reg, frame_height_next;
    logic [CMP_WW-1:0]    fw_ext;
    logic [CMP_HW-1:0]    fh_ext;
    reg_idx_t             idx;

    assign idx    = reg_idx_t'(paddr[REG_IDX_LSB]);
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready;

    always_comb begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_we) begin
            unique case (idx)
                REG_FRAME_WIDTH:  frame_width_next  = pwdata[CFG_DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_next = pwdata[CFG_DIM_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    always_comb begin
        unique case (idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_reg);
        endcase
    end

    // zero acts as one, oversize acts as the maximum
    assign fw_ext = CMP_WW'(frame_width_reg);
    assign fh_ext = CMP_HW'(frame_height_reg);

    always_comb begin
        if (fw_ext == '0) begin
            width_eff = WDW'(1);
        end else if (fw_ext > CMP_WW'(WIDTH_LIMIT)) begin
            width_eff = WDW'(WIDTH_LIMIT);
        end else begin
            width_eff = fw_ext[WDW-1:0];
        end
        if (fh_ext == '0) begin
            height_eff = HDW'(1);
        end else if (fh_ext > CMP_HW'(MAX_HEIGHT)) begin
            height_eff = HDW'(MAX_HEIGHT);
        end else begin
            height_eff = fh_ext[HDW-1:0];
        end
    end

endmodule

// File: sv/rhbd_ctrl.sv
// rhbd_ctrl: raster position tracking, held even-column pixel, per-request decisions
// depends on rhbd_pkg; drives the line store read address

module rhbd_ctrl import rhbd_pkg::*; #(
    parameter int unsigned WIDTH_LIMIT = DEF_WIDTH_LIMIT,
    parameter int unsigned MAX_HEIGHT  = DEF_MAX_HEIGHT,
    localparam int unsigned WDW    = $clog2(WIDTH_LIMIT + 1),
    localparam int unsigned HDW    = $clog2(MAX_HEIGHT + 1),
    localparam int unsigned DEPTH  = WIDTH_LIMIT / 2,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic              cfg_we,
    input  logic [WDW-1:0]    width_eff,
    input  logic [HDW-1:0]    height_eff,
    input  pix_in_t           s_data,
    output pix_in_t           held,
    output rhbd_ctl_t         ctl,
    output logic [ADDR_W-1:0] line_addr
);

    localparam int unsigned CW = $clog2(WIDTH_LIMIT);
    localparam int unsigned RW = $clog2(MAX_HEIGHT);

    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    pix_in_t        held_reg, held_next;
    logic [WDW-1:0] nw_raw, nw;
    logic [HDW-1:0] nh_raw, nh;
    logic [CW-1:0]  oc;
    logic [RW-1:0]  orow;
    logic           w_one, h_one, col_last, row_last, have_pair;

    assign w_one    = (width_eff == WDW'(1));
    assign h_one    = (height_eff == HDW'(1));
    assign nw_raw   = width_eff >> 1;
    assign nh_raw   = height_eff >> 1;
    assign nw       = (nw_raw == '0) ? WDW'(1) : nw_raw;
    assign nh       = (nh_raw == '0) ? HDW'(1) : nh_raw;
    assign col_last = (WDW'(col_reg) == width_eff - WDW'(1));
    assign row_last = (HDW'(row_reg) == height_eff - HDW'(1));

    assign oc        = w_one ? '0 : (col_reg >> 1);
    assign orow      = row_reg >> 1;
    assign have_pair = w_one | col_reg[0];

    always_comb begin
        ctl.self_pair  = w_one;
        ctl.double_row = h_one;
        ctl.wr_en      = have_pair & ~h_one & ~row_reg[0] & ~row_last;
        ctl.emit       = have_pair & (h_one | row_reg[0]);
        ctl.row_end    = (WDW'(oc) == nw - WDW'(1));
        ctl.frame_end  = ctl.row_end & (HDW'(orow) == nh - HDW'(1));
    end

    assign line_addr = oc[ADDR_W-1:0];
    assign held      = held_reg;

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        held_next = held_reg;
        if (accept && !w_one && !col_reg[0]) begin
            held_next = s_data;
        end
        if (cfg_we) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (col_last) begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + RW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            held_reg <= '0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            held_reg <= held_next;
        end
    end

    a_no_write_and_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> !(ctl.wr_en && ctl.emit))
        else $error("line store write and result on one request");

    a_cfg_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> (col_reg == '0) && (row_reg == '0))
        else $error("register write did not restart the frame");

    a_held_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !w_one && !col_reg[0] |=> held_reg == $past(s_data))
        else $error("even-column pixel not held");

endmodule

// File: sv/rhbd_datapath.sv
// rhbd_datapath: input stage register, pair and block sums, rounding, result register
// depends on rhbd_pkg; writes and reads the line store through the ram ports

module rhbd_datapath import rhbd_pkg::*; #(
    parameter int unsigned ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    output logic              in_ready,
    input  pix_in_t           s_data,
    input  pix_in_t           held,
    input  rhbd_ctl_t         ctl,
    input  logic [ADDR_W-1:0] line_addr,
    input  logic [LINE_W-1:0] ram_rdata,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_waddr,
    output logic [LINE_W-1:0] ram_wdata,
    output logic              m_valid,
    input  logic              m_ready,
    output pix_out_t          m_data
);

    logic              st1_valid_reg, st1_valid_next;
    rhbd_ctl_t         st1_ctl_reg;
    pix_in_t           st1_pix_reg, st1_held_reg;
    logic [ADDR_W-1:0] st1_addr_reg;
    logic              byp_reg;
    logic [LINE_W-1:0] byp_data_reg;
    logic              m_valid_reg, m_valid_next;
    pix_out_t          m_data_reg, m_data_next;

    logic              advance, st1_fire;
    logic [PAIR_W-1:0] pr_r, pr_g, pr_b;
    logic [LINE_W-1:0] pair_word, upper;
    logic [SUM_W-1:0]  sm_r, sm_g, sm_b;

    function automatic logic [PAIR_W-1:0] add_chan(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        return PAIR_W'(a) + PAIR_W'(b);
    endfunction

    function automatic logic [SUM_W-1:0] add_pair(input logic [PAIR_W-1:0] a,
                                                  input logic [PAIR_W-1:0] b);
        return SUM_W'(a) + SUM_W'(b);
    endfunction

    function automatic logic [CHAN_W-1:0] round_mean(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] t;
        t = s + SUM_W'(2);
        return t[SUM_W-1:2];
    endfunction

    assign advance  = ~m_valid_reg | m_ready;
    assign st1_fire = st1_valid_reg & advance;
    assign in_ready = ~st1_valid_reg | advance;

    // horizontal pair, single column pairs with itself
    always_comb begin
        if (st1_ctl_reg.self_pair) begin
            pr_r = add_chan(st1_pix_reg.pix_red, st1_pix_reg.pix_red);
            pr_g = add_chan(st1_pix_reg.pix_green, st1_pix_reg.pix_green);
            pr_b = add_chan(st1_pix_reg.pix_blue, st1_pix_reg.pix_blue);
        end else begin
            pr_r = add_chan(st1_held_reg.pix_red, st1_pix_reg.pix_red);
            pr_g = add_chan(st1_held_reg.pix_green, st1_pix_reg.pix_green);
            pr_b = add_chan(st1_held_reg.pix_blue, st1_pix_reg.pix_blue);
        end
    end

    assign pair_word = {pr_r, pr_g, pr_b};
    assign upper     = byp_reg ? byp_data_reg : ram_rdata;

    // vertical sum, single row pairs with itself
    always_comb begin
        if (st1_ctl_reg.double_row) begin
            sm_r = add_pair(pr_r, pr_r);
            sm_g = add_pair(pr_g, pr_g);
            sm_b = add_pair(pr_b, pr_b);
        end else begin
            sm_r = add_pair(upper[3*PAIR_W-1:2*PAIR_W], pr_r);
            sm_g = add_pair(upper[2*PAIR_W-1:PAIR_W], pr_g);
            sm_b = add_pair(upper[PAIR_W-1:0], pr_b);
        end
    end

    assign ram_we    = st1_fire & st1_ctl_reg.wr_en;
    assign ram_waddr = st1_addr_reg;
    assign ram_wdata = pair_word;

    always_comb begin
        st1_valid_next = st1_valid_reg;
        if (accept) begin
            st1_valid_next = 1'b1;
        end else if (st1_fire) begin
            st1_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next          = m_valid_reg;
        m_data_next           = m_data_reg;
        m_data_next.out_red   = round_mean(sm_r);
        m_data_next.out_green = round_mean(sm_g);
        m_data_next.out_blue  = round_mean(sm_b);
        m_data_next.row_end   = st1_ctl_reg.row_end;
        m_data_next.frame_end = st1_ctl_reg.frame_end;
        if (st1_fire && st1_ctl_reg.emit) begin
            m_valid_next = 1'b1;
        end else begin
            m_data_next = m_data_reg;
            if (m_ready) begin
                m_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers; forward a same-address write that the read missed
    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_ctl_reg  <= ctl;
            st1_pix_reg  <= s_data;
            st1_held_reg <= held;
            st1_addr_reg <= line_addr;
            byp_reg      <= ram_we && (ram_waddr == line_addr);
            byp_data_reg <= pair_word;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_frame_end_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.frame_end |-> m_data_reg.row_end)
        else $error("frame end without row end");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_valid_reg && !advance |=> st1_valid_reg && $stable(st1_pix_reg))
        else $error("stalled request lost from input stage");

    a_emit_reaches_out: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_fire && st1_ctl_reg.emit |=> m_valid_reg)
        else $error("result not loaded into output register");

endmodule

// File: sv/rgb_half_box_downscale.sv
// rgb_half_box_downscale: 2x2 box-filter downscale of an rgb pixel stream
// the lower-right pixel passes the input stage register and then the result register
// throughput: one pixel per cycle while no result waits, set by the single-pass sum stage and the line store port
// a waiting result holds the sum stage, and s_ready then follows m_ready
// reset: synchronous active low; clears position and handshake state, size 640x480
// the line store is not cleared; entries are written before they are read

module rgb_half_box_downscale import rhbd_pkg::*; #(
    parameter int unsigned WIDTH_LIMIT = DEF_WIDTH_LIMIT,
    parameter int unsigned MAX_HEIGHT  = DEF_MAX_HEIGHT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pix_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pix_out_t              m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int unsigned WDW    = $clog2(WIDTH_LIMIT + 1);
    localparam int unsigned HDW    = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned DEPTH  = WIDTH_LIMIT / 2;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WDW-1:0]    width_eff;
    logic [HDW-1:0]    height_eff;
    logic              cfg_we;
    logic              accept;
    pix_in_t           held;
    rhbd_ctl_t         ctl;
    logic [ADDR_W-1:0] line_addr;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [LINE_W-1:0] ram_wdata;
    logic [LINE_W-1:0] ram_rdata;

    assign accept = s_valid & s_ready;

    rhbd_regs #(
        .WIDTH_LIMIT (WIDTH_LIMIT),
        .MAX_HEIGHT  (MAX_HEIGHT)
    ) u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .cfg_we     (cfg_we)
    );

    rhbd_ctrl #(
        .WIDTH_LIMIT (WIDTH_LIMIT),
        .MAX_HEIGHT  (MAX_HEIGHT)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .cfg_we     (cfg_we),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .s_data     (s_data),
        .held       (held),
        .ctl        (ctl),
        .line_addr  (line_addr)
    );

    rhbd_ram #(
        .WIDTH (LINE_W),
        .DEPTH (DEPTH)
    ) u_line (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (line_addr),
        .rdata (ram_rdata)
    );

    rhbd_datapath #(
        .ADDR_W (ADDR_W)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .in_ready  (s_ready),
        .s_data    (s_data),
        .held      (held),
        .ctl       (ctl),
        .line_addr (line_addr),
        .ram_rdata (ram_rdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
